[src/jump_search_sorted_table_defines.svh]
// ----------------------------------------------------------------------------
// Jump search sorted table: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef JUMP_SEARCH_SORTED_TABLE_DEFINES_SVH
`define JUMP_SEARCH_SORTED_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define JSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define JSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/jss_pkg.sv]
// ----------------------------------------------------------------------------
// jss_pkg
// Types and constants shared by the jump search table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jss_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 32;
  localparam int ADDR_W      = 10;   // slot and position width
  localparam int LEN_W       = 11;   // length and walk counters, up to depth + jump
  localparam int JUMP_W      = 6;    // floor(sqrt(TABLE_DEPTH)) fits
  localparam int SQ_W        = 2 * JUMP_W;
  localparam int BIT_W       = 3;    // bit index of the root search
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS  = 2'd1;

  typedef struct packed {
    logic                     op;
    logic [ADDR_W-1:0]        slot;
    logic signed [KEY_BITS-1:0] key;
  } jss_in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } jss_out_t;

  // Controller to datapath
  typedef struct packed {
    logic ram_we;      // write the request key into its slot
    logic latch_key;   // capture the search key
    logic init_jump;   // start = 0, next = jump
    logic clip_read;   // clip next to length, read block end
    logic advance;     // start = next, next += jump
    logic scan_start;  // index = start
    logic scan_read;   // read entry at index
    logic scan_inc;    // index += 1
    logic res_hit;     // result: found at index
    logic res_miss;    // result: not found
    logic out_load;    // move result into output register
  } jss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sqrt_busy;   // jump size still being worked out
    logic empty;       // length or jump size is zero
    logic key_le;      // key <= entry read, in selected order
    logic key_eq;      // key == entry read
    logic walk_end;    // block end reached the table end
    logic scan_last;   // index is the last entry of the block
  } jss_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_JRD,
    S_JCMP,
    S_SRD,
    S_SCMP,
    S_DONE
  } jss_state_t;

endpackage

[src/jss_ram.sv]
// ----------------------------------------------------------------------------
// jss_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/jss_isqrt.sv]
// ----------------------------------------------------------------------------
// jss_isqrt
// Integer square root of the table length, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_isqrt import jss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LEN_W-1:0]  n,
  output logic              busy,
  output logic [JUMP_W-1:0] root
);

  logic [JUMP_W-1:0] root_r, root_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              busy_r, busy_nxt;
  logic [JUMP_W-1:0] trial;
  logic [SQ_W-1:0]   trial_sq;

  // Try setting the current bit, keep it if the square still fits
  always_comb begin
    trial    = root_r | (JUMP_W'(1) << bit_r);
    trial_sq = SQ_W'(trial) * SQ_W'(trial);
    root_nxt = root_r;
    n_nxt    = n_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      root_nxt = '0;
      n_nxt    = n;
      bit_nxt  = BIT_W'(JUMP_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial_sq <= SQ_W'(n_r)) begin
        root_nxt = trial;
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        bit_nxt = bit_r - BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      root_r <= root_nxt;
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
    end
    n_r <= n_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[src/jss_datapath.sv]
// ----------------------------------------------------------------------------
// jss_datapath
// Key store, configuration, walk counters, comparators and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_datapath import jss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  jss_in_t               in_data,
  input  jss_cmd_t              cmd,
  output jss_sts_t              sts,
  output jss_out_t              out_data
);

  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                sgn_r, sgn_nxt;
  logic [LEN_W-1:0]    len_sat;
  logic                sqrt_start;
  logic                sqrt_busy;
  logic [JUMP_W-1:0]   jump;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [LEN_W-1:0]    start_r, start_nxt;
  logic [LEN_W-1:0]    next_r, next_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic                res_found_r, res_found_nxt;
  logic [ADDR_W-1:0]   res_pos_r, res_pos_nxt;
  jss_out_t            out_r, out_nxt;

  logic [LEN_W-1:0]    clip;
  logic [LEN_W-1:0]    clip_m1;
  logic [LEN_W-1:0]    idx_inc;
  logic [ADDR_W-1:0]   ram_addr;
  logic [KEY_BITS-1:0] ram_rdata;
  logic [KEY_BITS-1:0] ord_key;
  logic [KEY_BITS-1:0] ord_ent;

  // Configuration registers; length saturates at the table depth
  always_comb begin
    len_sat    = (cfg_data > CFG_DATA_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                       : LEN_W'(cfg_data);
    len_nxt    = len_r;
    sgn_nxt    = sgn_r;
    sqrt_start = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_LENGTH: begin
          len_nxt    = len_sat;
          sqrt_start = 1'b1;
        end
        CFG_SIGNED_KEYS: sgn_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  jss_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (len_sat),
    .busy  (sqrt_busy),
    .root  (jump)
  );

  // Key store
  always_comb begin
    clip    = (next_r > len_r) ? len_r : next_r;
    clip_m1 = clip - LEN_W'(1);
    idx_inc = idx_r + LEN_W'(1);
    if (cmd.ram_we) begin
      ram_addr = in_data.slot;
    end else if (cmd.clip_read) begin
      ram_addr = clip_m1[ADDR_W-1:0];
    end else begin
      ram_addr = idx_r[ADDR_W-1:0];
    end
  end

  jss_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (in_data.key),
    .rdata (ram_rdata)
  );

  // Walk counters and result
  always_comb begin
    key_nxt       = key_r;
    start_nxt     = start_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_nxt       = out_r;
    if (cmd.latch_key) key_nxt = in_data.key;
    if (cmd.init_jump) begin
      start_nxt = '0;
      next_nxt  = LEN_W'(jump);
    end
    if (cmd.clip_read) next_nxt = clip;
    if (cmd.advance) begin
      start_nxt = next_r;
      next_nxt  = next_r + LEN_W'(jump);
    end
    if (cmd.scan_start) idx_nxt = start_r;
    if (cmd.scan_inc)   idx_nxt = idx_inc;
    if (cmd.res_hit) begin
      res_found_nxt = 1'b1;
      res_pos_nxt   = idx_r[ADDR_W-1:0];
    end
    if (cmd.res_miss) begin
      res_found_nxt = 1'b0;
      res_pos_nxt   = '0;
    end
    if (cmd.out_load) begin
      out_nxt.found    = res_found_r;
      out_nxt.position = res_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      sgn_r <= 1'b1;
    end else begin
      len_r <= len_nxt;
      sgn_r <= sgn_nxt;
    end
    key_r       <= key_nxt;
    start_r     <= start_nxt;
    next_r      <= next_nxt;
    idx_r       <= idx_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_r       <= out_nxt;
  end

  // Status; signed order is unsigned order with the sign bit flipped
  always_comb begin
    ord_key        = {key_r[KEY_BITS-1] ^ sgn_r, key_r[KEY_BITS-2:0]};
    ord_ent        = {ram_rdata[KEY_BITS-1] ^ sgn_r, ram_rdata[KEY_BITS-2:0]};
    sts.sqrt_busy  = sqrt_busy;
    sts.empty      = (len_r == '0) || (jump == '0);
    sts.key_le     = ord_key <= ord_ent;
    sts.key_eq     = ram_rdata == key_r;
    sts.walk_end   = next_r >= len_r;
    sts.scan_last  = idx_inc >= next_r;
  end

  assign out_data = out_r;

endmodule

[src/jss_ctrl.sv]
// ----------------------------------------------------------------------------
// jss_ctrl
// Search sequencer: accepts requests, walks block ends, scans one block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_ctrl import jss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  jss_sts_t sts,
  output jss_cmd_t cmd
);

  jss_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall = !((state_r == S_IDLE) && !sts.sqrt_busy);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && (in_op == OP_SEARCH)) state_nxt = S_INIT;
      S_INIT: state_nxt = sts.empty ? S_DONE : S_JRD;
      S_JRD:  state_nxt = S_JCMP;
      S_JCMP: begin
        if (sts.key_le) begin
          state_nxt = S_SRD;
        end else if (sts.walk_end) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_JRD;
        end
      end
      S_SRD:  state_nxt = S_SCMP;
      S_SCMP: state_nxt = (sts.key_eq || sts.scan_last) ? S_DONE : S_SRD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.ram_we    = accept && (in_op == OP_LOAD);
        cmd.latch_key = accept && (in_op == OP_SEARCH);
      end
      S_INIT: begin
        cmd.res_miss  = sts.empty;
        cmd.init_jump = !sts.empty;
      end
      S_JRD: cmd.clip_read = 1'b1;
      S_JCMP: begin
        cmd.scan_start = sts.key_le;
        cmd.advance    = !sts.key_le;
        cmd.res_miss   = !sts.key_le && sts.walk_end;
      end
      S_SRD: cmd.scan_read = 1'b1;
      S_SCMP: begin
        cmd.res_hit  = sts.key_eq;
        cmd.res_miss = !sts.key_eq && sts.scan_last;
        cmd.scan_inc = !sts.key_eq && !sts.scan_last;
      end
      S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // Output valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/jump_search_sorted_table.sv]
// Jump search over a table of up to 1024 sorted 32-bit keys. A load request
// (op 0) writes its key into a slot and gives no result. A search request
// (op 1) walks block ends jump_size apart, jump_size being the integer square
// root of table_length, then scans the first block whose end is not less than
// the key; one result (found, position) follows. Every key read goes through
// the single-port key RAM with its registered read, so each block end and each
// scanned entry takes a read state and then a compare state (S_JRD, S_JCMP and
// S_SRD, S_SCMP), and one request is handled at a time. The output register
// lets the next request in while a result waits. Writing table_length starts
// the square root, during which requests stall. Configuration is taken at any
// cycle (cfg_ready is always high) but must only be written while the block is
// idle.
`timescale 1ns / 1ps

`include "jump_search_sorted_table_defines.svh"

module jump_search_sorted_table import jss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  jss_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output jss_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  jss_cmd_t cmd;
  jss_sts_t sts;

  assign cfg_ready = 1'b1;

  jss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  jss_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // No request taken while the jump size is being worked out
  `JSS_ASSERT_NOW(a_stall_sqrt, sts.sqrt_busy, in_stall, "request taken during square root")
  // Key RAM written only by an accepted load request
  `JSS_ASSERT_NOW(a_we_load, cmd.ram_we, in_valid && !in_stall && (in_data.op == OP_LOAD), "stray key write")
  // A pending result is never overwritten
  `JSS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result overwritten")
  // Loading a result presents it in the next cycle
  `JSS_ASSERT_NEXT(a_out_shown, cmd.out_load, out_valid, "loaded result not shown")

endmodule
